FILE: hw/rtl/srbs_pkg.sv
// Shared types and constants for the sorted range bounds search block.
package srbs_pkg;

  localparam int IDX_W = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SRCH,
    ST_DONE
  } srbs_state_t;

  typedef struct packed {
    logic start;
    logic take;
  } srbs_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } srbs_sts_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] last;
    logic             found;
  } srbs_res_t;

endpackage

FILE: hw/rtl/srbs_mem.sv
// Element store: one write port, one registered read port.
module srbs_mem #(
  parameter int DEPTH = 1024,
  parameter int ELEM_WIDTH = 32,
  parameter int AW = 10
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [ELEM_WIDTH-1:0] wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [ELEM_WIDTH-1:0] rd_data
);

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/srbs_search.sv
// Search sequencer: two binary searches, one memory probe per cycle.
module srbs_search #(
  parameter int DEPTH = 1024,
  parameter int ELEM_WIDTH = 32,
  parameter int CW = 11,
  parameter int AW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srbs_pkg::srbs_ctl_t   ctl,
  input  logic [ELEM_WIDTH-1:0] key,
  input  logic [CW-1:0]         cnt,
  output srbs_pkg::srbs_sts_t   sts,
  output srbs_pkg::srbs_res_t   res,
  output logic                  rd_en,
  output logic [AW-1:0]         rd_addr,
  input  logic [ELEM_WIDTH-1:0] rd_data
);
  import srbs_pkg::*;

  localparam int SW = CW + 1;

  srbs_state_t state_r, state_nxt;
  logic pass_r, pend_r;
  logic first_v_r, last_v_r;
  logic [ELEM_WIDTH-1:0] key_r;
  logic [CW-1:0] cnt_r;
  logic signed [SW-1:0] s_r, e_r, mid_r;
  logic [IDX_W-1:0] first_r, last_r;

  logic signed [SW-1:0] s_upd, e_upd, diff_c, mid_c;
  logic w_eq, w_gt, w_lt, go_c;

  always_comb begin
    w_eq = (rd_data == key_r);
    w_gt = (rd_data > key_r);
    w_lt = (rd_data < key_r);
    s_upd = s_r;
    e_upd = e_r;
    if (state_r == ST_SRCH && pend_r) begin
      if (!pass_r) begin
        if (w_eq || w_gt) begin
          e_upd = mid_r - SW'(1);
        end else begin
          s_upd = mid_r + SW'(1);
        end
      end else begin
        if (w_eq || w_lt) begin
          s_upd = mid_r + SW'(1);
        end else begin
          e_upd = mid_r - SW'(1);
        end
      end
    end
    diff_c = e_upd - s_upd;
    mid_c = s_upd + (diff_c >>> 1);
    go_c = (s_upd <= e_upd);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.start) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_SRCH;
      ST_SRCH: begin
        if (!go_c) state_nxt = pass_r ? ST_DONE : ST_SETUP;
      end
      ST_DONE: begin
        if (ctl.take) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = 1'b1;
    sts.done = 1'b0;
    rd_en = 1'b0;
    unique case (state_r)
      ST_IDLE:  sts.busy = 1'b0;
      ST_SETUP: ;
      ST_SRCH:  rd_en = go_c;
      ST_DONE:  sts.done = 1'b1;
      default:  sts.busy = 1'b0;
    endcase
  end

  assign rd_addr = mid_c[AW-1:0];

  assign res.first = first_v_r ? first_r : '1;
  assign res.last  = last_v_r ? last_r : '1;
  assign res.found = first_v_r | last_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pass_r    <= 1'b0;
      pend_r    <= 1'b0;
      first_v_r <= 1'b0;
      last_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (ctl.start) begin
            pass_r    <= 1'b0;
            first_v_r <= 1'b0;
            last_v_r  <= 1'b0;
          end
        end
        ST_SETUP: pend_r <= 1'b0;
        ST_SRCH: begin
          pend_r <= go_c;
          if (pend_r && w_eq) begin
            if (pass_r) last_v_r <= 1'b1;
            else first_v_r <= 1'b1;
          end
          if (!go_c && !pass_r) pass_r <= 1'b1;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && ctl.start) begin
      key_r <= key;
      cnt_r <= cnt;
    end
    if (state_r == ST_SETUP) begin
      s_r <= '0;
      e_r <= $signed({1'b0, cnt_r}) - SW'(1);
    end
    if (state_r == ST_SRCH) begin
      s_r   <= s_upd;
      e_r   <= e_upd;
      mid_r <= mid_c;
      if (pend_r && w_eq) begin
        if (pass_r) last_r <= IDX_W'(mid_r);
        else first_r <= IDX_W'(mid_r);
      end
    end
  end

endmodule

FILE: hw/rtl/sorted_range_bounds_search.sv
// Top level of the sorted range bounds search block.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   in      | input     | in_valid, in_stall, in_mode, in_start_new,
//           |           | in_element, in_target
//   out     | output    | out_valid, out_stall, out_first_index,
//           |           | out_last_index, out_found
//
// An append transfer yields no result. A query runs two binary searches,
// one for the first index and one for the last, each making at most
// floor(log2(count)) + 1 probes, one element memory read a probe.
// Reset empties the array through the element count; memory contents stay.
// in_stall is high while a query runs; a finished result waits in the output
// register while out_stall is high, and the next input transfer is taken.
module sorted_range_bounds_search #(
  parameter int DEPTH = 1024,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_mode,
  input  logic                                in_start_new,
  input  logic signed [31:0]                  in_element,
  input  logic signed [31:0]                  in_target,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [srbs_pkg::IDX_W-1:0]   out_first_index,
  output logic signed [srbs_pkg::IDX_W-1:0]   out_last_index,
  output logic                                out_found
);
  import srbs_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ELEM_WIDTH-1:0] SIGN_MSK = ELEM_WIDTH'(1) << (ELEM_WIDTH - 1);

  srbs_ctl_t ctl;
  srbs_sts_t sts;
  srbs_res_t res;

  logic [CW-1:0] count_r, count_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] first_r, last_r;
  logic found_r;

  logic in_xfer, app, slot_free;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [ELEM_WIDTH-1:0] elem_key, tgt_key;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic [ELEM_WIDTH-1:0] rd_data;

  assign in_stall  = sts.busy;
  assign in_xfer   = in_valid && !in_stall;
  assign app       = in_xfer && !in_mode;
  assign slot_free = !out_valid_r || !out_stall;

  assign elem_key = ELEM_WIDTH'($unsigned(in_element)) ^ SIGN_MSK;
  assign tgt_key  = ELEM_WIDTH'($unsigned(in_target)) ^ SIGN_MSK;

  assign ctl.start = in_xfer && in_mode;
  assign ctl.take  = sts.done && slot_free;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = count_r[AW-1:0];
    count_nxt = count_r;
    if (app) begin
      if (in_start_new) begin
        wr_en = 1'b1;
        wr_addr = '0;
        count_nxt = CW'(1);
      end else if (count_r < CW'(DEPTH)) begin
        wr_en = 1'b1;
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.take) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      first_r <= res.first;
      last_r  <= res.last;
      found_r <= res.found;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_first_index = $signed(first_r);
  assign out_last_index  = $signed(last_r);
  assign out_found       = found_r;

  srbs_mem #(
    .DEPTH(DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(elem_key),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  srbs_search #(
    .DEPTH(DEPTH),
    .ELEM_WIDTH(ELEM_WIDTH),
    .CW(CW),
    .AW(AW)
  ) u_search (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .key(tgt_key),
    .cnt(count_r),
    .sts(sts),
    .res(res),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

FILE: hw/rtl/srbs_checker.sv
// Port-level checks for the sorted range bounds search block, with bind.
module srbs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_mode,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [srbs_pkg::IDX_W-1:0] out_first_index,
  input logic signed [srbs_pkg::IDX_W-1:0] out_last_index,
  input logic                              out_found
);
  import srbs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_first_index)
      && $stable(out_last_index) && $stable(out_found))
    else $error("stalled result changed");

  a_miss_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_first_index == '1 && out_last_index == '1)
    else $error("miss with index set");

  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_first_index != '1 || out_last_index != '1) |-> out_found)
    else $error("index set without found");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=> in_stall)
    else $error("query transfer did not raise stall");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without search");

endmodule

bind sorted_range_bounds_search srbs_checker u_srbs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_mode(in_mode),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_first_index(out_first_index),
  .out_last_index(out_last_index),
  .out_found(out_found)
);
